### rtl/bfbpt_pkg.sv
// ----------------------------------------------------------------------------
// bfbpt_pkg: shared types and constants of the block parking table
// Slot count, field widths, operation and register codes, and the structs
// that run along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bfbpt_pkg;

    localparam int SLOTS    = 32;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int KEY_W    = 64;
    localparam int HGT_W    = 64;
    localparam int SIZE_W   = 20;
    localparam int BYTES_W  = 26;
    localparam int QUOTA_W  = 6;
    localparam int LIM_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int OUT_CNT_W = 6;

    localparam logic [FUNC_W-1:0] FUNC_PRUNE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PARK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTA       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEAD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE     = 2'd3;

    localparam logic [BYTES_W-1:0] RST_BYTE_BUDGET = 26'd1048576;
    localparam logic [QUOTA_W-1:0] RST_QUOTA       = 6'd4;
    localparam logic [LIM_W-1:0]   RST_MAX_LEAD    = 32'd64;
    localparam logic [LIM_W-1:0]   RST_MAX_AGE     = 32'd16;

    // operation held stable for the whole sweep
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  peer;
        logic [HGT_W-1:0]  height;
        logic [HGT_W-1:0]  head;
        logic [SIZE_W-1:0] size;
        logic [KEY_W-1:0]  digest;
        logic [LIM_W-1:0]  max_lead;
        logic [LIM_W-1:0]  max_age;
    } t_query;

    // sweep token handed from cell to cell
    typedef struct packed {
        logic               active;
        logic [CNT_W-1:0]   same_peer;
        logic               dup;
        logic               free_found;
        logic [CNT_W-1:0]   gone;
        logic [BYTES_W-1:0] freed;
    } t_token;

endpackage

`default_nettype wire

### rtl/bounded_future_block_parking_table.sv
// ----------------------------------------------------------------------------
// bounded_future_block_parking_table: admission table for future frames
// Park, prune and clear operations over a chain of slot cells.
// ----------------------------------------------------------------------------
// Flow: the start transfer sets an inject flag, then one token walks the SLOTS
// cells, one cell per cycle, and the result is registered behind the last cell.
// A new operation is taken only once the last one is through; busy high meanwhile.
// The receiver cannot stall: o_valid is high for a single cycle; results then hold.
// Reset (synchronous, active low) empties the table and restores the limits.
`default_nettype none

module bounded_future_block_parking_table (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [bfbpt_pkg::FUNC_W-1:0]      i_func,
    input  wire logic [bfbpt_pkg::KEY_W-1:0]       i_peer_key,
    input  wire logic [bfbpt_pkg::HGT_W-1:0]       i_claimed_height,
    input  wire logic [bfbpt_pkg::HGT_W-1:0]       i_head_height,
    input  wire logic [bfbpt_pkg::SIZE_W-1:0]      i_frame_size,
    input  wire logic [bfbpt_pkg::KEY_W-1:0]       i_frame_digest,
    input  wire logic                              i_cfg_we,
    input  wire logic [bfbpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bfbpt_pkg::CFG_DAT_W-1:0]   i_cfg_wdata,
    output logic                                   o_valid,
    output logic                                   o_queued,
    output logic [bfbpt_pkg::OUT_CNT_W-1:0]        o_evicted,
    output logic [bfbpt_pkg::OUT_CNT_W-1:0]        o_entry_count,
    output logic [bfbpt_pkg::BYTES_W-1:0]          o_byte_total
);
    import bfbpt_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state             r_state;
    logic               r_inject;
    t_query             r_query;
    logic [BYTES_W-1:0] r_budget;
    logic [QUOTA_W-1:0] r_quota;
    logic [LIM_W-1:0]   r_max_lead;
    logic [LIM_W-1:0]   r_max_age;
    logic [CNT_W-1:0]   r_count;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_valid;
    logic               r_queued;
    logic [CNT_W-1:0]   r_evicted;

    t_query             query;
    t_token             tok [SLOTS+1];
    t_token             last;

    logic               accept;
    logic               finish;
    logic               park_ok;
    logic               commit;
    logic [BYTES_W:0]   bytes_after;
    logic [HGT_W-1:0]   lead;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign last   = tok[SLOTS];
    assign finish = (r_state == S_SCAN) && last.active;

    assign query = r_query;

    always_comb begin
        tok[0]        = '0;
        tok[0].active = r_inject;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        bfbpt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_query  (query),
            .i_tok    (tok[g]),
            .i_commit (commit),
            .o_tok    (tok[g+1])
        );
    end

    // park checks in order: full, budget, quota, not ahead, too far
    always_comb begin
        bytes_after = {1'b0, r_bytes} + (BYTES_W+1)'(r_query.size);
        lead        = r_query.height - r_query.head;
        park_ok     = (r_count < CNT_W'(SLOTS))
                      && (bytes_after <= {1'b0, r_budget})
                      && (last.same_peer < CNT_W'(r_quota))
                      && (r_query.height > r_query.head)
                      && (lead <= HGT_W'(r_query.max_lead));
        commit      = finish && (r_query.func == FUNC_PARK) && park_ok
                      && !last.dup && last.free_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_inject   <= 1'b0;
            r_valid    <= 1'b0;
            r_count    <= '0;
            r_bytes    <= '0;
            r_budget   <= RST_BYTE_BUDGET;
            r_quota    <= RST_QUOTA;
            r_max_lead <= RST_MAX_LEAD;
            r_max_age  <= RST_MAX_AGE;
        end else begin
            r_inject <= accept;
            r_valid  <= finish;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BYTE_BUDGET: r_budget   <= i_cfg_wdata[BYTES_W-1:0];
                    CFG_QUOTA:       r_quota    <= i_cfg_wdata[QUOTA_W-1:0];
                    CFG_MAX_LEAD:    r_max_lead <= i_cfg_wdata[LIM_W-1:0];
                    CFG_MAX_AGE:     r_max_age  <= i_cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (finish) begin
                        r_state   <= S_IDLE;
                        r_queued  <= 1'b0;
                        r_evicted <= '0;
                        case (r_query.func)
                            FUNC_PRUNE: begin
                                r_evicted <= last.gone;
                                r_count   <= r_count - last.gone;
                                r_bytes   <= r_bytes - last.freed;
                            end
                            FUNC_PARK: begin
                                r_queued <= park_ok;
                                if (commit) begin
                                    r_count <= r_count + CNT_W'(1);
                                    r_bytes <= bytes_after[BYTES_W-1:0];
                                end
                            end
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_bytes <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // operation fields and limits ride along into the cells; held for the sweep
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query.func     <= i_func;
            r_query.peer     <= i_peer_key;
            r_query.height   <= i_claimed_height;
            r_query.head     <= i_head_height;
            r_query.size     <= i_frame_size;
            r_query.digest   <= i_frame_digest;
            r_query.max_lead <= r_max_lead;
            r_query.max_age  <= r_max_age;
        end
    end

    assign o_valid       = r_valid;
    assign o_queued      = r_queued;
    assign o_evicted     = OUT_CNT_W'(r_evicted);
    assign o_entry_count = OUT_CNT_W'(r_count);
    assign o_byte_total  = r_bytes;

endmodule

`default_nettype wire

### rtl/bfbpt_cell.sv
// ----------------------------------------------------------------------------
// bfbpt_cell: one slot of the parking table
// Holds one entry, checks it against the operation as the sweep token
// passes, and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbpt_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bfbpt_pkg::t_query i_query,
    input  wire bfbpt_pkg::t_token i_tok,
    input  wire logic              i_commit,
    output bfbpt_pkg::t_token      o_tok
);
    import bfbpt_pkg::*;

    logic              r_valid;
    logic              r_claim;
    logic [HGT_W-1:0]  r_height;
    logic [HGT_W-1:0]  r_parked;
    logic [SIZE_W-1:0] r_size;
    logic [KEY_W-1:0]  r_peer;
    logic [KEY_W-1:0]  r_digest;
    t_token            r_tok;
    t_token            n_tok;

    logic             hit_peer;
    logic             hit_dup;
    logic             mine;
    logic             drop;
    logic             do_prune;
    logic [HGT_W-1:0] lead;
    logic [HGT_W-1:0] age;

    always_comb begin
        lead     = r_height - i_query.head;
        age      = i_query.head - r_parked;
        hit_peer = r_valid && (r_peer == i_query.peer);
        hit_dup  = r_valid && (r_height == i_query.height) && (r_size == i_query.size)
                   && (r_digest == i_query.digest);
        mine     = !r_valid && !i_tok.free_found;
        drop     = r_valid && ((r_height <= i_query.head)
                   || (lead > HGT_W'(i_query.max_lead))
                   || ((i_query.head >= r_parked) && (age > HGT_W'(i_query.max_age))));
        do_prune = i_tok.active && (i_query.func == FUNC_PRUNE) && drop;

        n_tok            = i_tok;
        n_tok.same_peer  = i_tok.same_peer + CNT_W'(hit_peer);
        n_tok.dup        = i_tok.dup | hit_dup;
        n_tok.free_found = i_tok.free_found | !r_valid;
        n_tok.gone       = i_tok.gone + CNT_W'(do_prune);
        n_tok.freed      = i_tok.freed + (do_prune ? BYTES_W'(r_size) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_claim <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.active) begin
                r_claim <= mine;
            end
            if (i_commit && r_claim) begin
                r_valid <= 1'b1;
            end else if (i_tok.active && (i_query.func == FUNC_CLEAR)) begin
                r_valid <= 1'b0;
            end else if (do_prune) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload takes the parked frame; no reset needed
    always_ff @(posedge i_clk) begin
        if (i_commit && r_claim) begin
            r_height <= i_query.height;
            r_parked <= i_query.head;
            r_size   <= i_query.size;
            r_peer   <= i_query.peer;
            r_digest <= i_query.digest;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire
